### rtl/mspfp_pkg.sv
// MSP v2 frame parser package: item types, byte codes, status codes and CRC-8 DVB-S2 update.
// No dependencies; used by every module of the parser.
`timescale 1ns / 1ps
package mspfp_pkg;

  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_X     = 8'h58;  // 'X'
  localparam logic [7:0] CH_ERR   = 8'h21;  // '!'
  localparam logic [7:0] CH_REQ   = 8'h3E;  // '>'
  localparam logic [7:0] CH_RESP  = 8'h3C;  // '<'

  localparam logic [7:0] CRC_POLY = 8'hD5;
  localparam logic [7:0] CRC_MSB  = 8'h80;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_HDR = 2'd1;
  localparam logic [1:0] ST_ERR_MSG = 2'd2;
  localparam logic [1:0] ST_BAD_CRC = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       abort;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic        is_request;
    logic [7:0]  flag;
    logic [15:0] command;
    logic [15:0] frame_len;
  } out_item_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/mspfp_in_if.sv
// Input channel of the MSP v2 frame parser: one received byte per item.
// Standalone; no package dependency.
`timescale 1ns / 1ps
interface mspfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       abort;

  modport source (output valid, output rx_byte, output abort, input ready);
  modport sink (input valid, input rx_byte, input abort, output ready);
  modport monitor (input valid, input ready, input rx_byte, input abort);
endinterface

### rtl/mspfp_out_if.sv
// Result channel of the MSP v2 frame parser: payload bytes and frame status items.
// Standalone; no package dependency.
`timescale 1ns / 1ps
interface mspfp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [1:0]  status;
  logic        is_request;
  logic [7:0]  flag;
  logic [15:0] command;
  logic [15:0] frame_len;

  modport source (output valid, output kind, output data_byte, output status,
                  output is_request, output flag, output command,
                  output frame_len, input ready);
  modport sink (input valid, input kind, input data_byte, input status,
                input is_request, input flag, input command,
                input frame_len, output ready);
  modport monitor (input valid, input ready, input kind, input data_byte,
                   input status, input is_request, input flag, input command,
                   input frame_len);
endinterface

### rtl/mspfp_in_stage.sv
// Input register of the MSP v2 frame parser: holds one accepted byte item.
// Depends on mspfp_pkg and mspfp_in_if.
`timescale 1ns / 1ps
module mspfp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  mspfp_in_if.sink           in_ch,
  input  logic               take,
  output logic               item_valid,
  output mspfp_pkg::in_item_t item
);

  logic                 valid_r;
  logic                 valid_nxt;
  mspfp_pkg::in_item_t  item_r;
  logic                 load;

  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.rx_byte <= in_ch.rx_byte;
      item_r.abort   <= in_ch.abort;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### rtl/mspfp_core.sv
// Frame state machine of the MSP v2 frame parser: header capture, CRC, payload count.
// Depends on mspfp_pkg.
`timescale 1ns / 1ps
module mspfp_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  mspfp_pkg::in_item_t  item,
  input  logic                 space,
  output logic                 take,
  output logic                 push,
  output mspfp_pkg::out_item_t res
);

  localparam logic [3:0] PH_HUNT    = 4'd0;
  localparam logic [3:0] PH_X       = 4'd1;
  localparam logic [3:0] PH_DIR     = 4'd2;
  localparam logic [3:0] PH_FLAG    = 4'd3;
  localparam logic [3:0] PH_CMD_LO  = 4'd4;
  localparam logic [3:0] PH_CMD_HI  = 4'd5;
  localparam logic [3:0] PH_LEN_LO  = 4'd6;
  localparam logic [3:0] PH_LEN_HI  = 4'd7;
  localparam logic [3:0] PH_PAYLOAD = 4'd8;
  localparam logic [3:0] PH_CRC     = 4'd9;

  logic [3:0]  phase_r,   phase_nxt;
  logic        dir_r,     dir_nxt;
  logic [7:0]  flag_r,    flag_nxt;
  logic [15:0] cmd_r,     cmd_nxt;
  logic [15:0] len_r,     len_nxt;
  logic [15:0] left_r,    left_nxt;
  logic [7:0]  crc_r,     crc_nxt;

  logic [3:0]  phase_eff;
  logic [7:0]  b;
  logic [7:0]  crc_step;
  logic [15:0] len_full;
  logic [15:0] left_dec;
  logic        hit;

  assign b         = item.rx_byte;
  assign phase_eff = item.abort ? PH_HUNT : phase_r;
  assign crc_step  = mspfp_pkg::crc8_update(crc_r, b);
  assign len_full  = {b, len_r[7:0]};
  assign left_dec  = left_r - 16'd1;

  always_comb begin
    phase_nxt = phase_eff;
    dir_nxt   = dir_r;
    flag_nxt  = flag_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    crc_nxt   = crc_r;
    hit       = 1'b0;
    res       = '0;
    unique case (phase_eff)
      PH_X: begin
        if (b == mspfp_pkg::CH_X) begin
          phase_nxt = PH_DIR;
        end else begin
          phase_nxt  = PH_HUNT;
          hit        = 1'b1;
          res.kind   = mspfp_pkg::KIND_STATUS;
          res.status = mspfp_pkg::ST_BAD_HDR;
        end
      end
      PH_DIR: begin
        if (b == mspfp_pkg::CH_REQ || b == mspfp_pkg::CH_RESP) begin
          dir_nxt   = (b == mspfp_pkg::CH_REQ);
          crc_nxt   = 8'h00;
          phase_nxt = PH_FLAG;
        end else begin
          phase_nxt  = PH_HUNT;
          hit        = 1'b1;
          res.kind   = mspfp_pkg::KIND_STATUS;
          res.status = (b == mspfp_pkg::CH_ERR) ? mspfp_pkg::ST_ERR_MSG
                                                : mspfp_pkg::ST_BAD_HDR;
        end
      end
      PH_FLAG: begin
        flag_nxt  = b;
        crc_nxt   = crc_step;
        phase_nxt = PH_CMD_LO;
      end
      PH_CMD_LO: begin
        cmd_nxt   = {8'h00, b};
        crc_nxt   = crc_step;
        phase_nxt = PH_CMD_HI;
      end
      PH_CMD_HI: begin
        cmd_nxt   = {b, cmd_r[7:0]};
        crc_nxt   = crc_step;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt   = {8'h00, b};
        crc_nxt   = crc_step;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt   = len_full;
        left_nxt  = len_full;
        crc_nxt   = crc_step;
        phase_nxt = (len_full == 16'd0) ? PH_CRC : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        crc_nxt       = crc_step;
        left_nxt      = left_dec;
        phase_nxt     = (left_dec == 16'd0) ? PH_CRC : PH_PAYLOAD;
        hit           = 1'b1;
        res.kind      = mspfp_pkg::KIND_DATA;
        res.data_byte = b;
      end
      PH_CRC: begin
        phase_nxt      = PH_HUNT;
        hit            = 1'b1;
        res.kind       = mspfp_pkg::KIND_STATUS;
        res.status     = (b == crc_r) ? mspfp_pkg::ST_OK : mspfp_pkg::ST_BAD_CRC;
        res.is_request = dir_r;
        res.flag       = flag_r;
        res.command    = cmd_r;
        res.frame_len  = len_r;
      end
      default: begin
        phase_nxt = (b == mspfp_pkg::CH_START) ? PH_X : PH_HUNT;
      end
    endcase
  end

  assign take = item_valid && (!hit || space);
  assign push = take && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      dir_r   <= 1'b0;
      flag_r  <= 8'h00;
      cmd_r   <= 16'h0000;
      len_r   <= 16'h0000;
      left_r  <= 16'h0000;
      crc_r   <= 8'h00;
    end else if (take) begin
      phase_r <= phase_nxt;
      dir_r   <= dir_nxt;
      flag_r  <= flag_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      crc_r   <= crc_nxt;
    end
  end

endmodule

### rtl/mspfp_out_stage.sv
// Result register of the MSP v2 frame parser: holds one item until the sink takes it.
// Depends on mspfp_pkg and mspfp_out_if.
`timescale 1ns / 1ps
module mspfp_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mspfp_pkg::out_item_t res,
  output logic                 space,
  mspfp_out_if.source          out_ch
);

  logic                  valid_r;
  logic                  valid_nxt;
  mspfp_pkg::out_item_t  res_r;

  assign space = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.kind       = res_r.kind;
  assign out_ch.data_byte  = res_r.data_byte;
  assign out_ch.status     = res_r.status;
  assign out_ch.is_request = res_r.is_request;
  assign out_ch.flag       = res_r.flag;
  assign out_ch.command    = res_r.command;
  assign out_ch.frame_len  = res_r.frame_len;

endmodule

### rtl/msp_v2_frame_parser.sv
// MSP v2 frame parser, top level: input register, frame state machine, result register.
// A byte is accepted into the input register; the state machine consumes it there and writes
// any result into the result register, from which the sink takes it. The throughput is one
// byte per cycle while the result register has room, set by the state update and CRC-8 step
// between the two registers. Reset (rst_n low, synchronous): both stages empty, parser
// hunting, header and CRC zero. Depends on mspfp_pkg, the channel interfaces and stages.
`timescale 1ns / 1ps
module msp_v2_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  mspfp_in_if.sink    in_ch,
  mspfp_out_if.source out_ch
);

  logic                  item_valid;
  mspfp_pkg::in_item_t   item;
  logic                  take;
  logic                  push;
  logic                  space;
  mspfp_pkg::out_item_t  res;

  mspfp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  mspfp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .space      (space),
    .take       (take),
    .push       (push),
    .res        (res)
  );

  mspfp_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .res    (res),
    .space  (space),
    .out_ch (out_ch)
  );

endmodule

### rtl/msp_v2_frame_parser_chk.sv
// Port-level checker for the MSP v2 frame parser, bound to the top level.
// Depends on mspfp_pkg; watches the channel signals of the top level.
`timescale 1ns / 1ps
module msp_v2_frame_parser_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [7:0]  out_data_byte,
  input logic [1:0]  out_status,
  input logic        out_is_request,
  input logic [7:0]  out_flag,
  input logic [15:0] out_command,
  input logic [15:0] out_frame_len
);

  a_data_item_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == mspfp_pkg::KIND_DATA |->
      out_status == mspfp_pkg::ST_OK && !out_is_request &&
      out_flag == 8'h00 && out_command == 16'h0000 &&
      out_frame_len == 16'h0000)
    else $error("payload item carries header fields");

  a_status_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == mspfp_pkg::KIND_STATUS |-> out_data_byte == 8'h00)
    else $error("status item carries a data byte");

  a_bad_hdr_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == mspfp_pkg::KIND_STATUS &&
    (out_status == mspfp_pkg::ST_BAD_HDR || out_status == mspfp_pkg::ST_ERR_MSG) |->
      !out_is_request && out_flag == 8'h00 && out_command == 16'h0000 &&
      out_frame_len == 16'h0000)
    else $error("header error item carries header fields");

  a_in_ready_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input blocked while the result side is free");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_data_byte) && $stable(out_kind) && $stable(out_is_request) &&
      $stable(out_flag) && $stable(out_command) && $stable(out_frame_len))
    else $error("result item changed while stalled");

endmodule

bind msp_v2_frame_parser msp_v2_frame_parser_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kind       (out_ch.kind),
  .out_data_byte  (out_ch.data_byte),
  .out_status     (out_ch.status),
  .out_is_request (out_ch.is_request),
  .out_flag       (out_ch.flag),
  .out_command    (out_ch.command),
  .out_frame_len  (out_ch.frame_len)
);

### tb/msp_v2_frame_parser_check.sv
// Frame checker for the MSP v2 frame parser: parses every accepted byte itself and compares
// each accepted result against the oldest parsed expectation. Depends on mspfp_pkg and
// the mspfp_in_if / mspfp_out_if channel interfaces.
`timescale 1ns / 1ps
module msp_v2_frame_parser_check (
  input  logic         clk,
  input  logic         rst_n,
  mspfp_in_if.monitor  in_mon,
  mspfp_out_if.monitor out_mon,
  output int           mismatches,
  output int           outstanding,
  output int           n_ok,
  output int           n_bad_crc,
  output int           n_rejected,
  output int           n_payload
);

  typedef enum logic [3:0] {
    P_HUNT, P_X, P_DIR, P_FLAG, P_CMD_LO, P_CMD_HI, P_LEN_LO, P_LEN_HI, P_PAYLOAD, P_CRC
  } parse_phase_t;

  parse_phase_t          ph;
  logic                  dir_req;
  logic [7:0]            hdr_flag;
  logic [15:0]           hdr_cmd;
  logic [15:0]           hdr_len;
  logic [15:0]           remaining;
  logic [7:0]            crc_acc;
  mspfp_pkg::out_item_t  parsed_q[$];

  function automatic logic [7:0] crc_dvb_s2(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = acc ^ b;
    repeat (8) begin
      fb = c[7];
      c  = c << 1;
      if (fb) begin
        c = c ^ mspfp_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic ab);
    mspfp_pkg::out_item_t r;
    r = '0;
    if (ab) begin
      ph = P_HUNT;
    end
    case (ph)
      P_X: begin
        if (b == mspfp_pkg::CH_X) begin
          ph = P_DIR;
        end else begin
          ph = P_HUNT;
          r.kind = mspfp_pkg::KIND_STATUS;
          r.status = mspfp_pkg::ST_BAD_HDR;
          parsed_q.insert(parsed_q.size(), r);
        end
      end
      P_DIR: begin
        if (b == mspfp_pkg::CH_REQ || b == mspfp_pkg::CH_RESP) begin
          dir_req = (b == mspfp_pkg::CH_REQ);
          crc_acc = 8'h00;
          ph = P_FLAG;
        end else begin
          ph = P_HUNT;
          r.kind = mspfp_pkg::KIND_STATUS;
          r.status = (b == mspfp_pkg::CH_ERR) ? mspfp_pkg::ST_ERR_MSG : mspfp_pkg::ST_BAD_HDR;
          parsed_q.insert(parsed_q.size(), r);
        end
      end
      P_FLAG: begin
        hdr_flag = b;
        crc_acc = crc_dvb_s2(crc_acc, b);
        ph = P_CMD_LO;
      end
      P_CMD_LO: begin
        hdr_cmd = {8'h00, b};
        crc_acc = crc_dvb_s2(crc_acc, b);
        ph = P_CMD_HI;
      end
      P_CMD_HI: begin
        hdr_cmd = {b, hdr_cmd[7:0]};
        crc_acc = crc_dvb_s2(crc_acc, b);
        ph = P_LEN_LO;
      end
      P_LEN_LO: begin
        hdr_len = {8'h00, b};
        crc_acc = crc_dvb_s2(crc_acc, b);
        ph = P_LEN_HI;
      end
      P_LEN_HI: begin
        hdr_len = {b, hdr_len[7:0]};
        crc_acc = crc_dvb_s2(crc_acc, b);
        remaining = hdr_len;
        ph = (hdr_len == 16'h0000) ? P_CRC : P_PAYLOAD;
      end
      P_PAYLOAD: begin
        crc_acc = crc_dvb_s2(crc_acc, b);
        remaining = remaining - 16'd1;
        if (remaining == 16'h0000) begin
          ph = P_CRC;
        end
        r.kind = mspfp_pkg::KIND_DATA;
        r.data_byte = b;
        parsed_q.insert(parsed_q.size(), r);
      end
      P_CRC: begin
        ph = P_HUNT;
        r.kind = mspfp_pkg::KIND_STATUS;
        r.status = (b == crc_acc) ? mspfp_pkg::ST_OK : mspfp_pkg::ST_BAD_CRC;
        r.is_request = dir_req;
        r.flag = hdr_flag;
        r.command = hdr_cmd;
        r.frame_len = hdr_len;
        parsed_q.insert(parsed_q.size(), r);
      end
      default: begin
        ph = (b == mspfp_pkg::CH_START) ? P_X : P_HUNT;
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    mspfp_pkg::out_item_t got;
    mspfp_pkg::out_item_t want;
    if (!rst_n) begin
      ph = P_HUNT;
      dir_req = 1'b0;
      hdr_flag = 8'h00;
      hdr_cmd = 16'h0000;
      hdr_len = 16'h0000;
      remaining = 16'h0000;
      crc_acc = 8'h00;
      parsed_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.kind = out_mon.kind;
        got.data_byte = out_mon.data_byte;
        got.status = out_mon.status;
        got.is_request = out_mon.is_request;
        got.flag = out_mon.flag;
        got.command = out_mon.command;
        got.frame_len = out_mon.frame_len;
        if (parsed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected item kind %0d data %02h status %0d", $realtime,
                     got.kind, got.data_byte, got.status);
          end
        end else begin
          want = parsed_q.pop_front();
          if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
              got.status !== want.status || got.is_request !== want.is_request ||
              got.flag !== want.flag || got.command !== want.command ||
              got.frame_len !== want.frame_len) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch (exp/got) kind %0d/%0d data %02h/%02h status %0d/%0d",
                       $realtime, want.kind, got.kind, want.data_byte, got.data_byte,
                       want.status, got.status);
              $display("  req %0d/%0d flag %02h/%02h cmd %04h/%04h len %04h/%04h",
                       want.is_request, got.is_request, want.flag, got.flag,
                       want.command, got.command, want.frame_len, got.frame_len);
            end
          end
          if (want.kind == mspfp_pkg::KIND_DATA) begin
            n_payload++;
          end else if (want.status == mspfp_pkg::ST_OK) begin
            n_ok++;
          end else if (want.status == mspfp_pkg::ST_BAD_CRC) begin
            n_bad_crc++;
          end else begin
            n_rejected++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        parse_byte(in_mon.rx_byte, in_mon.abort);
      end
    end
    outstanding = parsed_q.size();
  end

endmodule

### tb/msp_v2_frame_parser_tb.sv
// Testbench top for the MSP v2 frame parser: clock, reset, byte stream stimulus and result
// sink with random idling. Depends on mspfp_pkg, the channel interfaces, the parser and
// msp_v2_frame_parser_check.
`timescale 1ns / 1ps
module msp_v2_frame_parser_tb;

  logic clk = 1'b0;
  logic rst_n;

  int   mismatches;
  int   outstanding;
  int   n_ok;
  int   n_bad_crc;
  int   n_rejected;
  int   n_payload;

  int   n_sent;
  int   n_noise;
  bit   abort_next;
  bit   tx_calm;
  bit   rx_calm;
  bit   hold_done;
  bit   big_done;

  mspfp_in_if  in_ch ();
  mspfp_out_if out_ch ();

  msp_v2_frame_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  msp_v2_frame_parser_check frame_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .n_ok        (n_ok),
    .n_bad_crc   (n_bad_crc),
    .n_rejected  (n_rejected),
    .n_payload   (n_payload)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.abort   <= abort_next;
    abort_next = 1'b0;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
  endtask

  // keep > 0 cuts the frame after that many bytes and aborts on the next item
  task automatic send_frame(input logic [7:0] dir, input logic [7:0] flg,
                            input logic [15:0] cmd, input logic [15:0] len,
                            input bit good_crc, input int keep);
    logic [7:0] q[$];
    logic [7:0] crc;
    int         n;
    q = {mspfp_pkg::CH_START, mspfp_pkg::CH_X, dir, flg, cmd[7:0], cmd[15:8],
         len[7:0], len[15:8]};
    n = (keep > 0) ? keep : 8 + int'(len);
    while (q.size() < n) q.insert(q.size(), 8'($urandom));
    while (q.size() > n) void'(q.pop_back());
    if (keep == 0) begin
      crc = 8'h00;
      for (int i = 3; i < q.size(); i++) begin
        crc = mspfp_pkg::crc8_update(crc, q[i]);
      end
      q.insert(q.size(), good_crc ? crc : crc ^ (8'h01 << $urandom_range(0, 7)));
    end
    foreach (q[i]) begin
      send_byte(q[i]);
    end
    if (keep > 0) begin
      abort_next = 1'b1;
    end
  endtask

  function automatic logic [15:0] short_len();
    if ($urandom_range(0, 3) == 0) begin
      return 16'd0;
    end
    return ($urandom_range(0, 7) == 0) ? 16'($urandom_range(13, 40))
                                       : 16'($urandom_range(1, 12));
  endfunction

  initial begin : limit
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && n_sent >= 700) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      if ($urandom_range(0, 15) == 0) begin
        rx_calm = !rx_calm;
      end
      stall = rx_calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin : source
    int      pick;
    int      drain;
    logic [7:0]  b;
    logic [15:0] len;
    logic [7:0]  dir;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    in_ch.abort   <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'hFF);
    send_byte(mspfp_pkg::CH_START);
    send_byte(mspfp_pkg::CH_START);
    send_byte(mspfp_pkg::CH_START);
    send_byte(mspfp_pkg::CH_X);
    abort_next = 1'b1;
    send_byte(mspfp_pkg::CH_START);
    send_byte(mspfp_pkg::CH_X);
    send_byte(mspfp_pkg::CH_ERR);
    send_byte(mspfp_pkg::CH_START);
    send_byte(mspfp_pkg::CH_X);
    send_byte(8'h00);
    send_frame(mspfp_pkg::CH_REQ, 8'hFF, 16'hFFFF, 16'h0000, 1'b1, 0);
    send_frame(mspfp_pkg::CH_RESP, 8'h00, 16'h0000, 16'h0001, 1'b0, 0);

    while (n_sent - n_noise < 1600) begin
      if ($urandom_range(0, 15) == 0) begin
        tx_calm = !tx_calm;
      end
      dir  = $urandom_range(0, 1) ? mspfp_pkg::CH_REQ : mspfp_pkg::CH_RESP;
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        send_frame(dir, 8'($urandom), 16'($urandom), short_len(),
                   $urandom_range(0, 4) != 0, 0);
      end else if (pick < 78) begin
        len = 16'($urandom);
        send_frame(dir, 8'($urandom), 16'($urandom), len, 1'b1,
                   $urandom_range(1, 8 + ((len < 20) ? int'(len) : 20)));
        if ($urandom_range(0, 1)) begin
          send_byte(mspfp_pkg::CH_START);
          n_noise++;
        end
      end else if (pick < 88) begin
        send_byte(mspfp_pkg::CH_START);
        case ($urandom_range(0, 2))
          0: begin
            b = 8'($urandom);
            while (b == mspfp_pkg::CH_X) b = 8'($urandom);
            send_byte(b);
          end
          1: begin
            send_byte(mspfp_pkg::CH_X);
            b = 8'($urandom);
            while (b == mspfp_pkg::CH_REQ || b == mspfp_pkg::CH_RESP) b = 8'($urandom);
            send_byte(b);
          end
          default: begin
            send_byte(mspfp_pkg::CH_X);
            send_byte(mspfp_pkg::CH_ERR);
          end
        endcase
      end else if (pick < 97 || big_done) begin
        abort_next = abort_next || ($urandom_range(0, 1) != 0);
        send_byte(8'($urandom));
        n_noise++;
      end else begin
        big_done = 1'b1;
        send_frame(dir, 8'($urandom), 16'($urandom), 16'($urandom_range(256, 262)),
                   $urandom_range(0, 1) != 0, 0);
      end
    end
    in_ch.valid <= 1'b0;
    in_ch.abort <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    drain = 0;
    while (drain < 10) begin
      @(posedge clk);
      drain++;
    end

    $display("stream of %0d bytes: %0d good frames, %0d crc errors, %0d header rejects",
             n_sent, n_ok, n_bad_crc, n_rejected);
    $display("%0d payload bytes forwarded, long sink hold-off %0s", n_payload,
             hold_done ? "done" : "missed");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
